// ===== sv/assert_macros.svh =====
// Assertion helper macros for the cache directory checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, dropped during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");
// Next-cycle implication checked every clock, dropped during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");
`endif

// ===== sv/lwbcd_pkg.sv =====
// ---------------------------------------------------------------------------
// lwbcd_pkg
// Shared command and result kind codes, widths and result type of the cache directory.
// ---------------------------------------------------------------------------
package lwbcd_pkg;
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [2:0] KIND_HIT   = 3'd0;
	localparam logic [2:0] KIND_MISS  = 3'd1;
	localparam logic [2:0] KIND_WDONE = 3'd2;
	localparam logic [2:0] KIND_WB    = 3'd3;
	localparam logic [2:0] KIND_CLEAN = 3'd4;
	localparam logic [2:0] KIND_FDONE = 3'd5;

	localparam int LEN_W   = 25;
	localparam int TOTAL_W = 34;
	localparam int CAP_W   = 32;

	typedef struct packed {
		logic [2:0]       kind;
		logic [19:0]      piece;
		logic [23:0]      offs;
		logic [LEN_W-1:0] len;
		logic             last;
	} result_t;
endpackage

// ===== sv/lwbcd_ram.sv =====
// ---------------------------------------------------------------------------
// lwbcd_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module lwbcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== sv/lwbcd_out.sv =====
// ---------------------------------------------------------------------------
// lwbcd_out
// Output register: holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
module lwbcd_out import lwbcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    full,
	input  logic    stall,
	output result_t dout,
	output logic    valid
);
	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

	assign full  = valid_q && stall;
	assign valid = valid_q;
	assign dout  = data_q;
endmodule

// ===== sv/lru_writeback_block_cache_directory.sv =====
// ---------------------------------------------------------------------------
// lru_writeback_block_cache_directory
// Byte-budgeted LRU write-back block cache directory.
// ---------------------------------------------------------------------------
// An item takes a sequenced walk over the entry table: one entry is read
// from the key/size RAM per cycle while the walk is not held at an entry.
// A write checks the budget, evicts the LRU entry while over budget,
// walks for its key, then allocates (evicting the LRU victim of a full
// directory) and writes; a read walks for its key, ends on a hit and goes
// on as a write on a miss; a flush walks the table, emitting dirty entries.
// A stalled output holds the item in its emitting state. The single RAM
// port sets the pace of the walk. The block is not ready while an item
// is in work, and takes a capacity write only while idle with no item
// offered. Valid, dirty and recency ranks sit in flip-flops and reset at
// once.
module lru_writeback_block_cache_directory import lwbcd_pkg::*; #(
	parameter int ENTRIES         = 32,
	parameter int KEY_PIECE_BITS  = 20,
	parameter int KEY_OFFSET_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       cmd,
	input  logic [19:0]      piece_num,
	input  logic [23:0]      block_offset,
	input  logic [24:0]      length,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       kind,
	output logic [19:0]      piece_index_out,
	output logic [23:0]      block_offset_out,
	output logic [24:0]      length_out,
	output logic             last,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [31:0]      cfg_data
);
	localparam int IW    = $clog2(ENTRIES);
	localparam int KW    = KEY_PIECE_BITS + KEY_OFFSET_BITS;
	localparam int DW    = KW + LEN_W;
	localparam int CW    = $clog2(ENTRIES + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BUDG  = 4'd1; // check budget, start LRU walk if over it, else key walk
	localparam logic [3:0] ST_LRU   = 4'd2; // find max rank among valid
	localparam logic [3:0] ST_VRD   = 4'd3; // read victim
	localparam logic [3:0] ST_VEMIT = 4'd4;
	localparam logic [3:0] ST_FIND  = 4'd5; // walk RAM comparing key
	localparam logic [3:0] ST_ALLOC = 4'd6;
	localparam logic [3:0] ST_WR    = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;
	localparam logic [3:0] ST_FLUSH = 4'd9;
	localparam logic [3:0] ST_FEMIT = 4'd10;
	localparam logic [3:0] ST_RFIND = 4'd11; // read lookup walk
	localparam logic [3:0] ST_FRD   = 4'd12; // read dirty entry for flush

	logic [3:0]          state_q;
	logic [ENTRIES-1:0]  valid_q, dirty_q;
	logic [IW-1:0]       rank_q [ENTRIES];
	logic [TOTAL_W-1:0]  total_q;
	logic [CAP_W-1:0]    cap_q;
	logic [1:0]          cmd_q;
	logic [KW-1:0]       key_q;
	logic [LEN_W-1:0]    len_q;
	logic [CW-1:0]       idx_q;
	logic [IW-1:0]       sel_q;
	logic                found_q;
	logic                full_dir_q; // victim comes from allocation

	logic                ram_we;
	logic [IW-1:0]       ram_addr;
	logic [DW-1:0]       ram_wdata, ram_rdata;
	logic [KW-1:0]       rd_key;
	logic [LEN_W-1:0]    rd_len;
	logic [IW-1:0]       prev_idx;
	logic                prev_ok;
	logic [IW-1:0]       free_idx;

	logic                push, ofull;
	result_t             res, oq;

	assign rd_key = ram_rdata[DW-1 -: KW];
	assign rd_len = ram_rdata[LEN_W-1:0];
	assign prev_idx = IW'(idx_q - CW'(1));
	assign prev_ok  = (idx_q != '0);

	// lowest numbered free entry
	always_comb begin
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (!valid_q[i]) free_idx = IW'(i);
	end

	lwbcd_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	lwbcd_out u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .din(res), .full(ofull),
		.stall(out_stall), .dout(oq), .valid(out_valid)
	);

	assign kind             = oq.kind;
	assign piece_index_out  = oq.piece;
	assign block_offset_out = oq.offs;
	assign length_out       = oq.len;
	assign last             = oq.last;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;

	function automatic result_t mk(logic [2:0] k, logic [KW-1:0] key,
			logic [LEN_W-1:0] l, logic lst);
		result_t r;
		r.kind  = k;
		r.piece = 20'(key[KW-1 -: KEY_PIECE_BITS]);
		r.offs  = 24'(key[KEY_OFFSET_BITS-1:0]);
		r.len   = l;
		r.last  = lst;
		return r;
	endfunction

	// address and write control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q[IW-1:0];
		ram_wdata = {key_q, len_q};
		push      = 1'b0;
		res       = mk(KIND_HIT, key_q, len_q, 1'b0);
		unique case (state_q)
			ST_VRD, ST_VEMIT, ST_FRD, ST_FEMIT: ram_addr = sel_q;
			ST_WR: begin
				ram_addr = sel_q;
				ram_we   = 1'b1;
			end
			default: ;
		endcase
		if (state_q == ST_VEMIT && !ofull) begin
			push = 1'b1;
			res  = mk(dirty_q[sel_q] ? KIND_WB : KIND_CLEAN, rd_key, rd_len, 1'b0);
		end
		if (state_q == ST_DONE && !ofull) begin
			push = 1'b1;
			if (cmd_q == CMD_FLUSH) res = mk(KIND_FDONE, '0, '0, 1'b1);
			else if (cmd_q == CMD_WRITE) res = mk(KIND_WDONE, key_q, len_q, 1'b1);
			else if (found_q) res = mk(KIND_HIT, key_q, len_q, 1'b1);
			else res = mk(KIND_MISS, key_q, len_q, 1'b1);
		end
		if (state_q == ST_FEMIT && !ofull) begin
			push = 1'b1;
			res  = mk(KIND_WB, rd_key, rd_len, 1'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			dirty_q    <= '0;
			total_q    <= '0;
			cap_q      <= CAP_W'(4194304);
			idx_q      <= '0;
			sel_q      <= '0;
			found_q    <= 1'b0;
			full_dir_q <= 1'b0;
			cmd_q      <= CMD_READ;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= IW'(i);
		end else begin
			if (cfg_valid && cfg_ready) cap_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && cmd != CMD_NOP) begin
						cmd_q   <= cmd;
						key_q   <= {KEY_PIECE_BITS'(piece_num), KEY_OFFSET_BITS'(block_offset)};
						len_q   <= length;
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= (cmd == CMD_FLUSH) ? ST_FLUSH :
							(cmd == CMD_READ) ? ST_RFIND : ST_BUDG;
					end
				end
				ST_RFIND: begin
					// RAM read data is registered, so it belongs to the previous address
					if (prev_ok && valid_q[prev_idx] && rd_key == key_q) begin
						if (rd_len >= len_q) begin
							found_q <= 1'b1;
							len_q   <= rd_len;
							sel_q   <= prev_idx;
							for (int i = 0; i < ENTRIES; i++)
								if (rank_q[i] < rank_q[prev_idx]) rank_q[i] <= rank_q[i] + 1'b1;
							rank_q[prev_idx] <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_BUDG;
						end
					end else if (idx_q == CW'(ENTRIES)) begin
						state_q <= ST_BUDG;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_BUDG: begin
					idx_q      <= '0;
					found_q    <= 1'b0;
					full_dir_q <= 1'b0;
					if (total_q > TOTAL_W'(cap_q) && valid_q != '0) state_q <= ST_LRU;
					else state_q <= ST_FIND;
				end
				ST_LRU: begin
					if (idx_q == CW'(ENTRIES)) begin
						state_q <= ST_VRD;
					end else begin
						if (valid_q[idx_q[IW-1:0]] &&
								(!found_q || rank_q[idx_q[IW-1:0]] > rank_q[sel_q])) begin
							sel_q   <= idx_q[IW-1:0];
							found_q <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_VRD: state_q <= ST_VEMIT;
				ST_VEMIT: begin
					if (!ofull) begin
						total_q        <= total_q - TOTAL_W'(rd_len);
						valid_q[sel_q] <= 1'b0;
						dirty_q[sel_q] <= 1'b0;
						found_q        <= 1'b0;
						idx_q          <= '0;
						state_q        <= full_dir_q ? ST_WR : ST_BUDG;
					end
				end
				ST_FIND: begin
					if (prev_ok && valid_q[prev_idx] && rd_key == key_q) begin
						total_q <= total_q - TOTAL_W'(rd_len);
						sel_q   <= prev_idx;
						state_q <= ST_WR;
					end else if (idx_q == CW'(ENTRIES)) begin
						state_q <= ST_ALLOC;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_ALLOC: begin
					if (valid_q != '1) begin
						sel_q   <= free_idx;
						state_q <= ST_WR;
					end else begin
						full_dir_q <= 1'b1;
						found_q    <= 1'b0;
						idx_q      <= '0;
						state_q    <= ST_LRU;
					end
				end
				ST_WR: begin
					if (full_dir_q && valid_q[sel_q]) begin
						state_q <= ST_VRD; // unreachable guard
					end else begin
						valid_q[sel_q] <= 1'b1;
						dirty_q[sel_q] <= (cmd_q == CMD_WRITE);
						total_q        <= total_q + TOTAL_W'(len_q);
						for (int i = 0; i < ENTRIES; i++)
							if (rank_q[i] < rank_q[sel_q]) rank_q[i] <= rank_q[i] + 1'b1;
						rank_q[sel_q] <= '0;
						found_q       <= 1'b0;
						state_q       <= ST_DONE;
					end
				end
				ST_DONE: if (!ofull) state_q <= ST_IDLE;
				ST_FLUSH: begin
					if (prev_ok && valid_q[prev_idx] && dirty_q[prev_idx]) begin
						sel_q   <= prev_idx;
						state_q <= ST_FRD;
					end else if (idx_q == CW'(ENTRIES)) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FRD: state_q <= ST_FEMIT;
				ST_FEMIT: begin
					// rdata holds the entry at sel_q while the address stays there
					if (!ofull) begin
						dirty_q[sel_q] <= 1'b0;
						state_q        <= ST_FLUSH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/lwbcd_checker.sv =====
// ---------------------------------------------------------------------------
// lwbcd_checker
// Port-level checks on the cache directory, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module lwbcd_checker import lwbcd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic        last
);
	`ASSERT_IMPL(a_kind_range, clk, arst_n, out_valid, kind <= KIND_FDONE)
	`ASSERT_IMPL(a_done_last, clk, arst_n, out_valid && kind != KIND_WB && kind != KIND_CLEAN, last)
	`ASSERT_IMPL(a_evict_notlast, clk, arst_n, out_valid && (kind == KIND_WB || kind == KIND_CLEAN), !last)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall && cmd != CMD_NOP, in_stall)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind))
endmodule

bind lru_writeback_block_cache_directory lwbcd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
	.out_valid(out_valid), .out_stall(out_stall), .kind(kind), .last(last)
);
